@@ hw/rtl/p2y_pkg.sv @@
// Shared types and constants for the packed RGB to packed YUV converter.
// No dependencies; every module of the block imports this package.
package p2y_pkg;

  // Conversion modes as written to the mode register.
  localparam logic [2:0] MODE_RGB565    = 3'd0;
  localparam logic [2:0] MODE_ARGB4444  = 3'd1;
  localparam logic [2:0] MODE_RGBA4444  = 3'd2;
  localparam logic [2:0] MODE_ABGR8888  = 3'd3;
  localparam logic [2:0] MODE_ABGR4444  = 3'd4;
  localparam logic [2:0] MODE_ABGR1555  = 3'd5;

  // Output packing format carried down the pipeline.
  typedef enum logic [1:0] {
    FMT_ZERO = 2'd0,
    FMT_565  = 2'd1,
    FMT_4444 = 2'd2,
    FMT_1555 = 2'd3
  } fmt_e;

  // Width of one signed product and of the signed sums.
  localparam int unsigned PW = 17;

  // BT.601 integer coefficients.
  localparam logic signed [PW-1:0] C_YR = 17'sd66;
  localparam logic signed [PW-1:0] C_YG = 17'sd129;
  localparam logic signed [PW-1:0] C_YB = 17'sd25;
  localparam logic signed [PW-1:0] C_UR = -17'sd38;
  localparam logic signed [PW-1:0] C_UG = -17'sd74;
  localparam logic signed [PW-1:0] C_UB = 17'sd112;
  localparam logic signed [PW-1:0] C_VR = 17'sd112;
  localparam logic signed [PW-1:0] C_VG = -17'sd94;
  localparam logic signed [PW-1:0] C_VB = -17'sd18;

  localparam logic signed [PW-1:0] ROUND = 17'sd128;
  localparam logic [7:0]           OFF_Y = 8'd16;
  localparam logic [7:0]           OFF_C = 8'd128;

  // Unpacked pixel: channels widened to 8 bits.
  typedef struct packed {
    fmt_e       fmt;
    logic [3:0] alpha;  // 1555 keeps its single alpha bit in bit 3
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } unpk_t;

  // Registered products of the color matrix.
  typedef struct packed {
    fmt_e                 fmt;
    logic [3:0]           alpha;
    logic signed [PW-1:0] yr, yg, yb;
    logic signed [PW-1:0] ur, ug, ub;
    logic signed [PW-1:0] vr, vg, vb;
  } prod_t;

endpackage

@@ hw/rtl/p2y_unpack.sv @@
// First pipeline stage: unpacks the source pixel by mode and widens to 8 bits.
// Depends on p2y_pkg.
module p2y_unpack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     mode_i,
  input  logic           valid_i,
  output logic           stall_o,
  input  logic [31:0]    pixel_i,
  output logic           valid_o,
  input  logic           stall_i,
  output p2y_pkg::unpk_t data_o
);
  import p2y_pkg::*;

  logic  valid_q;
  logic  en;
  unpk_t data_d, data_q;
  logic [15:0] lo;

  assign lo = pixel_i[15:0];

  always_comb begin
    data_d = '0;
    unique case (mode_i)
      MODE_RGB565: begin
        data_d.fmt = FMT_565;
        data_d.r   = {lo[15:11], 3'b000};
        data_d.g   = {lo[10:5], 2'b00};
        data_d.b   = {lo[4:0], 3'b000};
      end
      MODE_ARGB4444: begin
        data_d.fmt   = FMT_4444;
        data_d.alpha = lo[15:12];
        data_d.r     = {lo[11:8], 4'b0000};
        data_d.g     = {lo[7:4], 4'b0000};
        data_d.b     = {lo[3:0], 4'b0000};
      end
      MODE_RGBA4444: begin
        data_d.fmt   = FMT_4444;
        data_d.r     = {lo[15:12], 4'b0000};
        data_d.g     = {lo[11:8], 4'b0000};
        data_d.b     = {lo[7:4], 4'b0000};
        data_d.alpha = lo[3:0];
      end
      MODE_ABGR8888: begin
        data_d.fmt   = FMT_4444;
        data_d.alpha = pixel_i[31:28];
        data_d.b     = {pixel_i[23:20], 4'b0000};
        data_d.g     = {pixel_i[15:12], 4'b0000};
        data_d.r     = {pixel_i[7:4], 4'b0000};
      end
      MODE_ABGR4444: begin
        data_d.fmt   = FMT_4444;
        data_d.alpha = lo[15:12];
        data_d.b     = {lo[11:8], 4'b0000};
        data_d.g     = {lo[7:4], 4'b0000};
        data_d.r     = {lo[3:0], 4'b0000};
      end
      MODE_ABGR1555: begin
        data_d.fmt   = FMT_1555;
        data_d.alpha = {pixel_i[31], 3'b000};
        data_d.b     = {pixel_i[23:19], 3'b000};
        data_d.g     = {pixel_i[15:11], 3'b000};
        data_d.r     = {pixel_i[7:3], 3'b000};
      end
      default: begin
        data_d.fmt = FMT_ZERO;
      end
    endcase
  end

  // The stage takes a new item whenever it is empty or its item moves on.
  assign en      = !valid_q || !stall_i;
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hw/rtl/p2y_matrix.sv @@
// Second pipeline stage: forms the nine constant-coefficient products.
// Depends on p2y_pkg.
module p2y_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  p2y_pkg::unpk_t data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output p2y_pkg::prod_t data_o
);
  import p2y_pkg::*;

  logic  valid_q;
  logic  en;
  prod_t data_d, data_q;
  logic signed [PW-1:0] r_s, g_s, b_s;

  assign r_s = signed'({{(PW-8){1'b0}}, data_i.r});
  assign g_s = signed'({{(PW-8){1'b0}}, data_i.g});
  assign b_s = signed'({{(PW-8){1'b0}}, data_i.b});

  always_comb begin
    data_d.fmt   = data_i.fmt;
    data_d.alpha = data_i.alpha;
    data_d.yr    = r_s * C_YR;
    data_d.yg    = g_s * C_YG;
    data_d.yb    = b_s * C_YB;
    data_d.ur    = r_s * C_UR;
    data_d.ug    = g_s * C_UG;
    data_d.ub    = b_s * C_UB;
    data_d.vr    = r_s * C_VR;
    data_d.vg    = g_s * C_VG;
    data_d.vb    = b_s * C_VB;
  end

  assign en      = !valid_q || !stall_i;
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hw/rtl/p2y_pack.sv @@
// Third pipeline stage: sums the products, rounds, offsets and packs the word.
// Depends on p2y_pkg; its register is the block's output register.
module p2y_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  p2y_pkg::prod_t data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output logic [15:0]    yuv_o
);
  import p2y_pkg::*;

  logic                 valid_q;
  logic                 en;
  logic [15:0]          yuv_d, yuv_q;
  logic signed [PW-1:0] sy, su, sv;
  logic [7:0]           y, u, v;

  assign sy = data_i.yr + data_i.yg + data_i.yb + ROUND;
  assign su = data_i.ur + data_i.ug + data_i.ub + ROUND;
  assign sv = data_i.vr + data_i.vg + data_i.vb + ROUND;

  // Bits 15:8 of the sum are the floor of the sum over 256, modulo 256.
  assign y = sy[15:8] + OFF_Y;
  assign u = su[15:8] + OFF_C;
  assign v = sv[15:8] + OFF_C;

  always_comb begin
    unique case (data_i.fmt)
      FMT_565:  yuv_d = {u[7:3], y[7:2], v[7:3]};
      FMT_4444: yuv_d = {data_i.alpha, y[7:4], u[7:4], v[7:4]};
      FMT_1555: yuv_d = {data_i.alpha[3], y[7:3], u[7:3], v[7:3]};
      default:  yuv_d = '0;
    endcase
  end

  assign en      = !valid_q || !stall_i;
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      yuv_q <= yuv_d;
    end
  end

  assign valid_o = valid_q;
  assign yuv_o   = yuv_q;

endmodule

@@ hw/rtl/packed_rgb_to_packed_yuv.sv @@
// Packed RGB to packed YUV pixel converter, BT.601 integer coefficients.
// Top level; instantiates p2y_unpack, p2y_matrix and p2y_pack, uses p2y_pkg.
//
// Usage:
//   The input channel carries one pixel_word per item (valid_i / stall_o);
//   the output channel carries one yuv_word per item (valid_o / stall_i).
//   Every item gives exactly one result.
//   conversion_mode is written through mode_we_i / mode_wdata_i while the
//   block is idle; modes 6 and 7 produce a zero word.
// Pipeline and throughput:
//   Three register stages: unpack, multiply, sum and pack. An item is registered
//   in each stage in that order, and one item is taken every cycle when the
//   output is not stalled. The rate is set by the three-stage pipeline, each
//   stage holding one item.
// Reset:
//   rst_ni clears all stage valid bits and sets the mode to RGB565.
// Stall:
//   Each stage holds its item while the stage after it is full and stalled;
//   empty stages further up keep filling, so up to three items wait inside
//   before stall_o rises. Nothing is lost or repeated.
module packed_rgb_to_packed_yuv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_we_i,
  input  logic [2:0]  mode_wdata_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] pixel_word_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] yuv_word_o
);
  import p2y_pkg::*;

  logic [2:0] mode_q;
  logic       s1_valid, s1_stall;
  logic       s2_valid, s2_stall;
  unpk_t      s1_data;
  prod_t      s2_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB565;
    end else if (mode_we_i) begin
      mode_q <= mode_wdata_i;
    end
  end

  p2y_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .pixel_i (pixel_word_i),
    .valid_o (s1_valid),
    .stall_i (s1_stall),
    .data_o  (s1_data)
  );

  p2y_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stall_o (s1_stall),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .stall_i (s2_stall),
    .data_o  (s2_data)
  );

  p2y_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .stall_o (s2_stall),
    .data_i  (s2_data),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .yuv_o   (yuv_word_o)
  );

endmodule
